[rtl/core/chacha_pkg.sv]
// Shared types, constants and the quarter-round half step for the ChaCha20 block.
// Used by chacha_keygen, chacha_byte_unit and chacha20_stream_cipher.
package chacha_pkg;

  localparam int DOUBLE_ROUNDS_DEFAULT = 10;
  localparam int BLOCK_WORDS = 16;
  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_BITS  = 512;
  localparam int OFFSET_W    = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY0          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY1          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY2          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY3          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NONCE_LOW     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_NONCE_HIGH    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_START_COUNTER = 3'd6;

  typedef logic [31:0] word_t;
  typedef logic [BLOCK_BITS-1:0] block_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
    logic [31:0]      start_counter;
  } cfg_t;

  // Requests from the byte side and the configuration port to the generator.
  typedef struct packed {
    logic  take;
    logic  restart;
    logic  flush;
    logic  set_counter;
    word_t counter_value;
  } ks_ctrl_t;

  // One half of a quarter round: the 16/12 rotations first, then the 8/7 ones.
  function automatic quad_t qr_half(input word_t a, input word_t b, input word_t c,
                                    input word_t d, input logic second);
    quad_t r;
    word_t x;
    word_t y;
    r.a = a + b;
    x   = d ^ r.a;
    r.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
    r.c = c + r.d;
    y   = b ^ r.c;
    r.b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
    return r;
  endfunction

endpackage

[rtl/core/chacha_keygen.sv]
// Iterative ChaCha20 keystream block generator with a one-block output slot.
// Depends on chacha_pkg for the config struct, control struct and round step.
module chacha_keygen #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  chacha_pkg::cfg_t    cfg,
  input  chacha_pkg::ks_ctrl_t ctrl,
  output logic                slot_valid,
  output chacha_pkg::block_t  slot_block
);

  localparam int ROUNDS  = 2 * DOUBLE_ROUNDS;
  localparam int RND_W   = $clog2(ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]        state;
  logic [RND_W-1:0]  rnd;
  logic              phase;
  logic [31:0]       counter;
  chacha_pkg::word_t work      [chacha_pkg::BLOCK_WORDS];
  chacha_pkg::word_t work_next [chacha_pkg::BLOCK_WORDS];
  chacha_pkg::word_t init      [chacha_pkg::BLOCK_WORDS];
  logic              abort;

  assign abort = ctrl.flush | ctrl.restart;

  always_comb begin
    init[0] = chacha_pkg::SIGMA0;
    init[1] = chacha_pkg::SIGMA1;
    init[2] = chacha_pkg::SIGMA2;
    init[3] = chacha_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i]     = cfg.key[i][31:0];
      init[4 + 2*i + 1] = cfg.key[i][63:32];
    end
    init[12] = counter;
    init[13] = cfg.nonce_low[31:0];
    init[14] = cfg.nonce_low[63:32];
    init[15] = cfg.nonce_high;
  end

  // Even rounds work on columns, odd rounds on diagonals; the four lanes are independent.
  always_comb begin
    logic [1:0]        lb;
    logic [1:0]        lc;
    logic [1:0]        ld;
    chacha_pkg::quad_t qo;
    work_next = work;
    for (int q = 0; q < 4; q++) begin
      lb = 2'(q + int'(rnd[0]));
      lc = 2'(q + 2 * int'(rnd[0]));
      ld = 2'(q + 3 * int'(rnd[0]));
      qo = chacha_pkg::qr_half(work[q], work[{2'd1, lb}], work[{2'd2, lc}],
                               work[{2'd3, ld}], phase);
      work_next[q]          = qo.a;
      work_next[{2'd1, lb}] = qo.b;
      work_next[{2'd2, lc}] = qo.c;
      work_next[{2'd3, ld}] = qo.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rnd        <= '0;
      phase      <= 1'b0;
      counter    <= '0;
      slot_valid <= 1'b0;
    end else begin
      if (ctrl.set_counter) begin
        counter <= ctrl.counter_value;
      end else if (ctrl.restart) begin
        counter <= cfg.start_counter;
      end else if (ctrl.take) begin
        counter <= counter + 32'd1;
      end

      if (abort) begin
        state      <= ST_IDLE;
        slot_valid <= 1'b0;
      end else if (ctrl.take) begin
        slot_valid <= 1'b0;
      end else begin
        case (state)
          ST_IDLE: begin
            if (!slot_valid) begin
              for (int i = 0; i < chacha_pkg::BLOCK_WORDS; i++) begin
                work[i] <= init[i];
              end
              rnd   <= '0;
              phase <= 1'b0;
              state <= ST_ROUND;
            end
          end
          ST_ROUND: begin
            work  <= work_next;
            phase <= ~phase;
            if (phase) begin
              rnd <= rnd + RND_W'(1);
              if (rnd == RND_LAST) begin
                state <= ST_FINAL;
              end
            end
          end
          ST_FINAL: begin
            for (int i = 0; i < chacha_pkg::BLOCK_WORDS; i++) begin
              slot_block[32*i +: 32] <= work[i] + init[i];
            end
            slot_valid <= 1'b1;
            state      <= ST_IDLE;
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/chacha_byte_unit.sv]
// Byte side: holds the block in use, XORs one byte per accepted request and
// drives the output register with a one-entry skid stage. Depends on chacha_pkg.
module chacha_byte_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         cipher_byte,
  output logic               end_of_message,
  input  logic               slot_valid,
  input  chacha_pkg::block_t slot_block,
  output logic               take,
  output logic               restart
);

  logic [chacha_pkg::OFFSET_W-1:0] offset;
  chacha_pkg::block_t              cur_block;
  chacha_pkg::block_t              src_block;
  logic                            need_block;
  logic                            accept;
  logic [7:0]                      result;
  logic                            skid_valid;
  logic [7:0]                      skid_byte;
  logic                            skid_last;

  assign need_block = (offset == '0);
  assign src_block  = need_block ? slot_block : cur_block;
  assign in_ready   = (!need_block || slot_valid) && !skid_valid;
  assign accept     = in_valid && in_ready;
  assign result     = data_byte ^ src_block[7:0];
  assign take       = accept && need_block;
  assign restart    = accept && last_byte;

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_block <= {8'd0, src_block[chacha_pkg::BLOCK_BITS-1:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset     <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        offset <= last_byte ? '0 : offset + 1'b1;
        if (!out_valid || out_ready) begin
          out_valid      <= 1'b1;
          cipher_byte    <= result;
          end_of_message <= last_byte;
        end else begin
          skid_valid <= 1'b1;
          skid_byte  <= result;
          skid_last  <= last_byte;
        end
      end else if (out_ready) begin
        if (skid_valid) begin
          cipher_byte    <= skid_byte;
          end_of_message <= skid_last;
          skid_valid     <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/core/chacha20_stream_cipher.sv]
// ChaCha20 stream cipher top level: configuration registers, keystream
// generator and byte unit. Depends on chacha_pkg, chacha_keygen, chacha_byte_unit.
//
// Usage: load the key, nonce and start counter through the write port
// (cfg_write, cfg_index, cfg_data), then stream message bytes on the in_valid /
// in_ready channel with last_byte on the final byte. Each byte comes back on
// out_valid / out_ready as cipher_byte, with end_of_message copied from last_byte.
// An accepted request's result is registered in the output register, or in the
// skid stage when the receiver stalls. Within a message one byte is taken per
// cycle while the receiver keeps up: the next keystream block is built while
// the current one drains, and at ten double rounds the iterative round unit
// finishes it before the 64 bytes in use run out. The first byte of each
// message, and the first byte after a configuration write that needs a new
// block, waits for a full block build, since the generator restarts at the
// start counter or with the new key. Reset clears the configuration registers
// to zero and empties the output stages; the first block is then built right
// away. When the receiver stalls, one result waits in the output register and
// one more in a skid stage, after which in_ready drops.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          cipher_byte,
  output logic                                end_of_message,
  input  logic                                cfg_write,
  input  logic [chacha_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data
);

  chacha_pkg::cfg_t     cfg;
  chacha_pkg::ks_ctrl_t ctrl;
  logic                 slot_valid;
  chacha_pkg::block_t   slot_block;
  logic                 take;
  logic                 restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        chacha_pkg::REG_KEY0:          cfg.key[0]        <= cfg_data;
        chacha_pkg::REG_KEY1:          cfg.key[1]        <= cfg_data;
        chacha_pkg::REG_KEY2:          cfg.key[2]        <= cfg_data;
        chacha_pkg::REG_KEY3:          cfg.key[3]        <= cfg_data;
        chacha_pkg::REG_NONCE_LOW:     cfg.nonce_low     <= cfg_data;
        chacha_pkg::REG_NONCE_HIGH:    cfg.nonce_high    <= cfg_data[31:0];
        chacha_pkg::REG_START_COUNTER: cfg.start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Any write drops a block built ahead; the block in use keeps its bytes.
  always_comb begin
    ctrl.take          = take;
    ctrl.restart       = restart;
    ctrl.flush         = cfg_write;
    ctrl.set_counter   = cfg_write && (cfg_index == chacha_pkg::REG_START_COUNTER);
    ctrl.counter_value = cfg_data[31:0];
  end

  chacha_keygen #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_keygen (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ctrl       (ctrl),
    .slot_valid (slot_valid),
    .slot_block (slot_block)
  );

  chacha_byte_unit u_byte (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cipher_byte    (cipher_byte),
    .end_of_message (end_of_message),
    .slot_valid     (slot_valid),
    .slot_block     (slot_block),
    .take           (take),
    .restart        (restart)
  );

endmodule
